@@ rtl/torus_source_route_walk_core_assert.svh @@
// Assertion macros shared by the route walker checker.
`ifndef TORUS_SOURCE_ROUTE_WALK_CORE_ASSERT_SVH
`define TORUS_SOURCE_ROUTE_WALK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSRW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSRW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/tsrw_pkg.sv @@
// Package for the torus source route walker: grid constants, tables and shared types.
`default_nettype none
package tsrw_pkg;

  localparam int GRID_WIDTH  = 4;
  localparam int GRID_HEIGHT = 4;

  localparam int XW        = $clog2(GRID_WIDTH);
  localparam int YW        = $clog2(GRID_HEIGHT);
  localparam int TILE_W    = 4;
  localparam int HOP_W     = 4;
  localparam int ROUTE_W   = 32;
  localparam int FIELD_W   = 2;
  localparam int MAX_MOVES = 15;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [FIELD_W-1:0] code_t;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_NORTH = 2'd0,
    REG_EAST  = 2'd1,
    REG_WEST  = 2'd2,
    REG_SOUTH = 2'd3
  } reg_idx_t;

  localparam code_t NORTH_RST = 2'd0;
  localparam code_t EAST_RST  = 2'd1;
  localparam code_t WEST_RST  = 2'd2;
  localparam code_t SOUTH_RST = 2'd3;

  typedef struct packed {
    code_t north;
    code_t east;
    code_t west;
    code_t south;
  } codes_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } st_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  typedef logic [15:0][XW-1:0] x_tab_t;
  typedef logic [15:0][YW-1:0] y_tab_t;

  // tile -> column, with out-of-grid columns folded back
  function automatic x_tab_t build_x_tab();
    x_tab_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = XW'((i / GRID_HEIGHT) % GRID_WIDTH);
    end
    return t;
  endfunction

  function automatic y_tab_t build_y_tab();
    y_tab_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = YW'(i % GRID_HEIGHT);
    end
    return t;
  endfunction

  localparam x_tab_t X_OF_TILE = build_x_tab();
  localparam y_tab_t Y_OF_TILE = build_y_tab();

  // tile index kept to 4 bits, so the product only needs its low nibble
  function automatic logic [TILE_W-1:0] tile_of(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
    logic [TILE_W-1:0] prod;
    prod = TILE_W'(x) * TILE_W'(GRID_HEIGHT);
    return prod + TILE_W'(y);
  endfunction

endpackage
`default_nettype wire

@@ rtl/torus_source_route_walk_core.sv @@
// Top level of the 2D torus source route walker.
//
// Input channel (in_*): one word per route: 32-bit route, source tile and
// expected destination. Output channel (out_*): one word per path position,
// hop 0 being the source tile, then one per tile visited; tlast marks the end.
// Config (cfg_*): APB registers for the north, east, west and south codes.
//
// Timing: hop 0 is shown the cycle after the route word is taken. Each
// further hop follows in the cycle after the previous one is taken, as the
// single-hop step unit in the datapath resolves one field per cycle while
// out_tready is high. A route makes 2 to 16 output words; in_tready is
// high only between routes.
//
// Reset (synchronous, rst_n low) returns the FSM to idle and the codes to
// north 0, east 1, west 2, south 3. When out_tready is low the current word
// holds and the walk pauses.
`default_nettype none
module torus_source_route_walk_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // route_word[31:0], source_tile[35:32], expected_dest[39:36]
  input  wire logic [tsrw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tile[3:0], hop_index[7:4], dest_mismatch[8], no_terminator[9], zeros above
  output logic      [tsrw_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tsrw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [tsrw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [tsrw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  tsrw_pkg::codes_t     codes;
  tsrw_pkg::dp_cmd_t    cmd;
  tsrw_pkg::dp_status_t status;

  tsrw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .codes       (codes)
  );

  tsrw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tsrw_dp u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .codes     (codes),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/tsrw_cfg.sv @@
// APB register block holding the four direction codes.
`default_nettype none
module tsrw_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tsrw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [tsrw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [tsrw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready,
  output tsrw_pkg::codes_t                     codes
);

  tsrw_pkg::codes_t   codes_r, codes_nxt;
  tsrw_pkg::reg_idx_t idx;
  logic               wr_en;
  tsrw_pkg::code_t    rd_code;

  assign cfg_pready = 1'b1;
  assign idx   = tsrw_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    codes_nxt = codes_r;
    if (wr_en) begin
      unique case (idx)
        tsrw_pkg::REG_NORTH: codes_nxt.north = cfg_pwdata[1:0];
        tsrw_pkg::REG_EAST:  codes_nxt.east  = cfg_pwdata[1:0];
        tsrw_pkg::REG_WEST:  codes_nxt.west  = cfg_pwdata[1:0];
        tsrw_pkg::REG_SOUTH: codes_nxt.south = cfg_pwdata[1:0];
        default:             codes_nxt = codes_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tsrw_pkg::REG_NORTH: rd_code = codes_r.north;
      tsrw_pkg::REG_EAST:  rd_code = codes_r.east;
      tsrw_pkg::REG_WEST:  rd_code = codes_r.west;
      tsrw_pkg::REG_SOUTH: rd_code = codes_r.south;
      default:             rd_code = '0;
    endcase
  end

  assign cfg_prdata = tsrw_pkg::CFG_DATA_W'(rd_code);
  assign codes      = codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.north <= tsrw_pkg::NORTH_RST;
      codes_r.east  <= tsrw_pkg::EAST_RST;
      codes_r.west  <= tsrw_pkg::WEST_RST;
      codes_r.south <= tsrw_pkg::SOUTH_RST;
    end else begin
      codes_r <= codes_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsrw_ctrl.sv @@
// Controller FSM: takes a route word, then sequences one hop result per output handshake.
`default_nettype none
module tsrw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire tsrw_pkg::dp_status_t status,
  output tsrw_pkg::dp_cmd_t         cmd
);

  tsrw_pkg::st_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsrw_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = tsrw_pkg::ST_SEND;
      end
      tsrw_pkg::ST_SEND: begin
        if (out_tready && status.last) state_nxt = tsrw_pkg::ST_IDLE;
      end
      default: state_nxt = tsrw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      tsrw_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      tsrw_pkg::ST_SEND: begin
        out_tvalid = 1'b1;
        cmd.step   = out_tready && !status.last;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsrw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsrw_dp.sv @@
// Datapath: route shifter, torus position, hop counter and the output word register.
`default_nettype none
module tsrw_dp (
  input  wire logic                           clk,
  input  wire logic [tsrw_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire tsrw_pkg::codes_t               codes,
  input  wire tsrw_pkg::dp_cmd_t              cmd,
  output tsrw_pkg::dp_status_t                status,
  output logic [tsrw_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  logic [tsrw_pkg::ROUTE_W-1:0] route_r, route_nxt;
  logic [tsrw_pkg::XW-1:0]      x_r, x_nxt;
  logic [tsrw_pkg::YW-1:0]      y_r, y_nxt;
  logic [tsrw_pkg::HOP_W-1:0]   hop_r, hop_nxt;
  logic [tsrw_pkg::TILE_W-1:0]  tile_r, tile_nxt;
  logic [tsrw_pkg::TILE_W-1:0]  dest_r, dest_nxt;
  logic                         last_r, last_nxt;
  logic                         mism_r, mism_nxt;
  logic                         fault_r, fault_nxt;

  logic [tsrw_pkg::ROUTE_W-1:0] in_route;
  logic [tsrw_pkg::TILE_W-1:0]  in_src;
  logic [tsrw_pkg::TILE_W-1:0]  in_dest;
  tsrw_pkg::code_t              cur, follow;
  logic [tsrw_pkg::XW-1:0]      x_mv;
  logic [tsrw_pkg::YW-1:0]      y_mv;
  logic [tsrw_pkg::HOP_W-1:0]   hop_inc;
  logic [tsrw_pkg::TILE_W-1:0]  tile_mv;
  logic                         term;
  logic                         out_of_fields;

  assign in_route = in_tdata[31:0];
  assign in_src   = in_tdata[35:32];
  assign in_dest  = in_tdata[39:36];

  assign cur    = route_r[31:30];
  assign follow = route_r[29:28];

  // first matching code wins: north, east, south, west
  always_comb begin
    x_mv = x_r;
    y_mv = y_r;
    if (cur == codes.north) begin
      y_mv = (y_r == tsrw_pkg::YW'(tsrw_pkg::GRID_HEIGHT - 1)) ? '0 : y_r + 1'b1;
    end else if (cur == codes.east) begin
      x_mv = (x_r == tsrw_pkg::XW'(tsrw_pkg::GRID_WIDTH - 1)) ? '0 : x_r + 1'b1;
    end else if (cur == codes.south) begin
      y_mv = (y_r == '0) ? tsrw_pkg::YW'(tsrw_pkg::GRID_HEIGHT - 1) : y_r - 1'b1;
    end else if (cur == codes.west) begin
      x_mv = (x_r == '0) ? tsrw_pkg::XW'(tsrw_pkg::GRID_WIDTH - 1) : x_r - 1'b1;
    end
  end

  assign hop_inc       = hop_r + 1'b1;
  assign tile_mv       = tsrw_pkg::tile_of(x_mv, y_mv);
  // terminator compares raw field codes
  assign term          = (cur == ~follow);
  assign out_of_fields = (hop_inc == tsrw_pkg::HOP_W'(tsrw_pkg::MAX_MOVES));

  always_comb begin
    route_nxt = route_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    hop_nxt   = hop_r;
    tile_nxt  = tile_r;
    dest_nxt  = dest_r;
    last_nxt  = last_r;
    mism_nxt  = mism_r;
    fault_nxt = fault_r;
    if (cmd.load) begin
      route_nxt = in_route;
      x_nxt     = tsrw_pkg::X_OF_TILE[in_src];
      y_nxt     = tsrw_pkg::Y_OF_TILE[in_src];
      hop_nxt   = '0;
      tile_nxt  = tsrw_pkg::tile_of(tsrw_pkg::X_OF_TILE[in_src],
                                    tsrw_pkg::Y_OF_TILE[in_src]);
      dest_nxt  = in_dest;
      last_nxt  = 1'b0;
      mism_nxt  = 1'b0;
      fault_nxt = 1'b0;
    end else if (cmd.step) begin
      route_nxt = {route_r[tsrw_pkg::ROUTE_W-3:0], 2'b00};
      x_nxt     = x_mv;
      y_nxt     = y_mv;
      hop_nxt   = hop_inc;
      tile_nxt  = tile_mv;
      last_nxt  = term || out_of_fields;
      mism_nxt  = (term || out_of_fields) && (tile_mv != dest_r);
      fault_nxt = !term && out_of_fields;
    end
  end

  always_ff @(posedge clk) begin
    route_r <= route_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    hop_r   <= hop_nxt;
    tile_r  <= tile_nxt;
    dest_r  <= dest_nxt;
    last_r  <= last_nxt;
    mism_r  <= mism_nxt;
    fault_r <= fault_nxt;
  end

  assign status.last = last_r;
  assign out_tdata   = {6'b0, fault_r, mism_r, hop_r, tile_r};
  assign out_tlast   = last_r;

endmodule
`default_nettype wire

@@ rtl/tsrw_checker.sv @@
// Port-level checker for the route walker, bound to the top level.
`default_nettype none
`include "torus_source_route_walk_core_assert.svh"
module tsrw_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [tsrw_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);

  // a route is taken only while no result is on offer
  `TSRW_ASSERT_IMP(a_one_route, in_tready, !out_tvalid)
  // the source tile comes out first
  `TSRW_ASSERT_NXT(a_hop_zero, in_tvalid && in_tready, out_tvalid && (out_tdata[7:4] == 4'd0))
  // hops count up by one within a route
  `TSRW_ASSERT_NXT(a_hop_seq, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[7:4] == $past(out_tdata[7:4]) + 4'd1))
  // a missing terminator only ends a full-length route
  `TSRW_ASSERT_IMP(a_fault_end, out_tvalid && out_tdata[9], out_tlast && (out_tdata[7:4] == 4'd15))
  // flags stay clear before the final word
  `TSRW_ASSERT_IMP(a_flags_last, out_tvalid && !out_tlast, out_tdata[9:8] == 2'b00)

endmodule

bind torus_source_route_walk_core tsrw_checker u_tsrw_checker (.*);
`default_nettype wire

@@ dv/torus_source_route_walk_core_test.sv @@
// Self-checking testbench for the torus source route walker core.
`timescale 1ns / 1ps
`default_nettype none
module torus_source_route_walk_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 24;
  localparam int ROUTES_PER_PHASE = 52;

  typedef struct packed {
    logic [tsrw_pkg::TILE_W-1:0] tile;
    logic [tsrw_pkg::HOP_W-1:0]  hop;
    logic                        last;
    logic                        mismatch;
    logic                        noterm;
  } hop_t;

  typedef struct packed {
    logic [tsrw_pkg::ROUTE_W-1:0] route;
    logic [tsrw_pkg::TILE_W-1:0]  src;
    logic [tsrw_pkg::TILE_W-1:0]  dest;
  } route_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [tsrw_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tsrw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [tsrw_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [tsrw_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [tsrw_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  torus_source_route_walk_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tsrw_pkg::codes_t dir_codes = '{north: tsrw_pkg::NORTH_RST, east: tsrw_pkg::EAST_RST,
                                  west: tsrw_pkg::WEST_RST, south: tsrw_pkg::SOUTH_RST};
  route_req_t routes_pending[$];
  hop_t hops_due[$];
  route_req_t in_word = '0;
  bit in_busy = 1'b0;
  bit in_fire = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int errors = 0;
  int cycle_cnt = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Walks the route on the torus and appends every path position to walk.
  // Returns the tile where the walk ends.
  function automatic logic [tsrw_pkg::TILE_W-1:0] walk_route(
      input tsrw_pkg::codes_t c,
      input logic [tsrw_pkg::ROUTE_W-1:0] route,
      input logic [tsrw_pkg::TILE_W-1:0] src,
      input logic [tsrw_pkg::TILE_W-1:0] dest,
      ref hop_t walk[$]);
    int unsigned x;
    int unsigned y;
    int unsigned moves;
    tsrw_pkg::code_t cur;
    tsrw_pkg::code_t prev;
    logic [tsrw_pkg::TILE_W-1:0] t;
    bit done;
    bit fault;
    hop_t pos_word;
    x = (int'(src) / tsrw_pkg::GRID_HEIGHT) % tsrw_pkg::GRID_WIDTH;
    y = int'(src) % tsrw_pkg::GRID_HEIGHT;
    t = tsrw_pkg::TILE_W'(x * tsrw_pkg::GRID_HEIGHT + y);
    pos_word = '{tile: t, hop: '0, last: 1'b0, mismatch: 1'b0, noterm: 1'b0};
    walk.insert(walk.size(), pos_word);
    cur = route[31:30];
    moves = 0;
    done = 1'b0;
    while (!done) begin
      // first match wins when codes collide; no match means stay put
      if (cur == c.north) y = (y + 1) % tsrw_pkg::GRID_HEIGHT;
      else if (cur == c.east) x = (x + 1) % tsrw_pkg::GRID_WIDTH;
      else if (cur == c.south) y = (y == 0) ? tsrw_pkg::GRID_HEIGHT - 1 : y - 1;
      else if (cur == c.west) x = (x == 0) ? tsrw_pkg::GRID_WIDTH - 1 : x - 1;
      prev = cur;
      moves++;
      cur = tsrw_pkg::code_t'(route >> (30 - 2 * moves));
      t = tsrw_pkg::TILE_W'(x * tsrw_pkg::GRID_HEIGHT + y);
      fault = 1'b0;
      if (prev == ~cur) done = 1'b1;
      else if (moves >= tsrw_pkg::MAX_MOVES) begin
        done = 1'b1;
        fault = 1'b1;
      end
      pos_word = '{tile: t, hop: tsrw_pkg::HOP_W'(moves), last: done,
                   mismatch: done && (t != dest), noterm: fault};
      walk.insert(walk.size(), pos_word);
    end
    return t;
  endfunction

  // Route with `moves` legal hops then a reversal; moves = 16 gives no terminator.
  function automatic logic [tsrw_pkg::ROUTE_W-1:0] make_route(input int moves);
    logic [tsrw_pkg::ROUTE_W-1:0] r;
    tsrw_pkg::code_t f;
    tsrw_pkg::code_t prev;
    r = $urandom;
    prev = '0;
    for (int i = 0; i < 16; i++) begin
      if (i == 0) f = tsrw_pkg::code_t'($urandom_range(0, 3));
      else if (i < moves) f = ~prev ^ tsrw_pkg::code_t'($urandom_range(1, 3));
      else if (i == moves) f = ~prev;
      else f = r[31 - 2 * i -: 2];
      r[31 - 2 * i -: 2] = f;
      prev = f;
    end
    return r;
  endfunction

  // tie: destination set to where the walk actually ends
  task automatic queue_route(input logic [tsrw_pkg::ROUTE_W-1:0] route,
                             input logic [tsrw_pkg::TILE_W-1:0] src,
                             input bit tie);
    hop_t scratch[$];
    logic [tsrw_pkg::TILE_W-1:0] dest;
    logic [tsrw_pkg::TILE_W-1:0] end_tile;
    route_req_t req;
    end_tile = walk_route(dir_codes, route, src, 4'd0, scratch);
    dest = tie ? end_tile : tsrw_pkg::TILE_W'($urandom_range(0, 15));
    req = '{route: route, src: src, dest: dest};
    routes_pending.insert(routes_pending.size(), req);
  endtask

  task automatic apb_access(input bit wr, input logic [tsrw_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [tsrw_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [tsrw_pkg::CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_code(input tsrw_pkg::reg_idx_t idx, input tsrw_pkg::code_t val);
    logic [tsrw_pkg::CFG_DATA_W-1:0] rd;
    logic [tsrw_pkg::CFG_ADDR_W-1:0] addr;
    addr = tsrw_pkg::CFG_ADDR_W'({idx, 2'b00});
    apb_access(1'b1, addr, tsrw_pkg::CFG_DATA_W'(val), rd);
    apb_access(1'b0, addr, '0, rd);
    if (rd !== tsrw_pkg::CFG_DATA_W'(val)) begin
      errors++;
      $display("%0t readback %s: expected %h got %h", $time, idx.name(),
               tsrw_pkg::CFG_DATA_W'(val), rd);
    end
    case (idx)
      tsrw_pkg::REG_NORTH: dir_codes.north = val;
      tsrw_pkg::REG_EAST:  dir_codes.east = val;
      tsrw_pkg::REG_WEST:  dir_codes.west = val;
      default:             dir_codes.south = val;
    endcase
  endtask

  task automatic load_codes(input tsrw_pkg::code_t n, input tsrw_pkg::code_t e,
                            input tsrw_pkg::code_t w, input tsrw_pkg::code_t s);
    set_code(tsrw_pkg::REG_NORTH, n);
    set_code(tsrw_pkg::REG_EAST, e);
    set_code(tsrw_pkg::REG_WEST, w);
    set_code(tsrw_pkg::REG_SOUTH, s);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (routes_pending.size() != 0 || in_busy || hops_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    int pick;
    logic [tsrw_pkg::ROUTE_W-1:0] r;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        r = make_route(($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5));
      else if (pick < 85) r = make_route(16);
      else r = $urandom;
      queue_route(r, tsrw_pkg::TILE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  // input side: one word per route, random gaps between words unless calm
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_busy && in_fire) in_busy = 1'b0;
      if (!in_busy) begin
        if (in_gap > 0) in_gap--;
        else if (routes_pending.size() != 0) begin
          if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 16) - 1;
          else begin
            in_word = routes_pending.pop_front();
            in_busy = 1'b1;
          end
        end
      end
      in_tvalid <= in_busy;
      in_tdata <= {in_word.dest, in_word.src, in_word.route};
    end
  end

  // output side backpressure
  always @(negedge clk) begin
    bit rdy;
    rdy = 1'b1;
    if (out_stall > 0) begin
      out_stall--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(1, 16) - 1;
      rdy = 1'b0;
    end
    out_tready <= rst_n && rdy;
  end

  always @(posedge clk) begin
    hop_t got;
    hop_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire)
      void'(walk_route(dir_codes, in_tdata[31:0], in_tdata[35:32], in_tdata[39:36], hops_due));
    if (rst_n && out_tvalid && out_tready) begin
      got = '{tile: out_tdata[3:0], hop: out_tdata[7:4], last: out_tlast,
              mismatch: out_tdata[8], noterm: out_tdata[9]};
      if (hops_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none got tile %0d hop %0d last %b dm %b nt %b",
                 $time, got.tile, got.hop, got.last, got.mismatch, got.noterm);
      end else begin
        want = hops_due.pop_front();
        if (got !== want) begin
          errors++;
          $display({"%0t word mismatch: expected tile %0d hop %0d last %b dm %b nt %b,",
                    " got tile %0d hop %0d last %b dm %b nt %b"},
                   $time, want.tile, want.hop, want.last, want.mismatch, want.noterm,
                   got.tile, got.hop, got.last, got.mismatch, got.noterm);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset codes: reversals, wraparound on every edge, long walks
    queue_route(32'h3FFF_FFFF, 4'd0, 1'b1);
    queue_route(32'h3FFF_FFFF, 4'd3, 1'b0);
    queue_route(32'hC000_0000, 4'd0, 1'b1);
    queue_route(32'h6000_0000, 4'd12, 1'b1);
    queue_route(32'h9000_0000, 4'd0, 1'b0);
    queue_route(32'h0000_0000, 4'd0, 1'b1);
    queue_route(32'hFFFF_FFFF, 4'd15, 1'b0);
    queue_route(32'h5555_5555, 4'd5, 1'b1);
    queue_route(32'hAAAA_AAAA, 4'd10, 1'b0);
    // reversal sitting in the sixteenth field ends the walk cleanly
    queue_route(32'h0000_0003, 4'd7, 1'b1);
    queue_route(32'h0000_0003, 4'd15, 1'b0);
    queue_route(make_route(15), 4'd9, 1'b1);
    queue_route(make_route(16), 4'd6, 1'b1);
    queue_route(make_route(1), 4'd15, 1'b0);
    queue_random(ROUTES_PER_PHASE);
    wait_idle();

    load_codes(2'd3, 2'd2, 2'd1, 2'd0);
    queue_random(ROUTES_PER_PHASE);
    wait_idle();

    // every field collides on one code or matches nothing
    load_codes(2'd0, 2'd0, 2'd0, 2'd0);
    queue_route(32'h1B1B_1B1B, 4'd0, 1'b1);
    queue_random(ROUTES_PER_PHASE);
    wait_idle();

    load_codes(2'd3, 2'd3, 2'd3, 2'd3);
    queue_random(ROUTES_PER_PHASE);
    wait_idle();

    load_codes(tsrw_pkg::code_t'($urandom_range(0, 3)), tsrw_pkg::code_t'($urandom_range(0, 3)),
               tsrw_pkg::code_t'($urandom_range(0, 3)), tsrw_pkg::code_t'($urandom_range(0, 3)));
    calm = 1'b1;
    queue_random(ROUTES_PER_PHASE);
    wait_idle();

    if (hops_due.size() != 0) begin
      errors++;
      $display("%0t words missing: expected %0d more got none", $time, hops_due.size());
    end
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
